/* sv/cdq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque: operation codes,
// field widths and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int KIND_W  = 3;
  localparam int VALUE_W = 32;
  localparam int CAP_W   = 5;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;

  localparam logic [CAP_W-1:0]          CAP_RESET   = 5'd16;
  localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

  // controller -> datapath
  typedef struct packed {
    logic cfg_we;    // capacity write, empties the deque
    logic load_in;   // capture an input transaction
    logic exec;      // update pointers and write the slot
    logic rd;        // read front and rear slots
    logic load_out;  // fill the output register
  } cdq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_hold;  // output register full and stalled
  } cdq_sts_t;

endpackage
`default_nettype wire

/* sv/cdq_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer: accept, execute, read slots, load the output register.
// ----------------------------------------------------------------------------
module cdq_ctrl
  import cdq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire cdq_sts_t sts,
  output cdq_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_LOAD
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_stall     = 1'b1;
    cfg_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cfg_ready   = 1'b1;
        cmd.cfg_we  = cfg_valid;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // hold until the output register frees up
        if (!sts.out_hold) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/cdq_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_dp
// Datapath: capacity register, head/tail pointers, slot memory with one
// write and two registered read ports, and the output register.
// ----------------------------------------------------------------------------
module cdq_dp
  import cdq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire cdq_cmd_t                  cmd,
  output cdq_sts_t                       sts,
  input  wire logic [CAP_W-1:0]          cfg_data,
  input  wire logic [KIND_W-1:0]         in_kind,
  input  wire logic signed [VALUE_W-1:0] in_value,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_accepted,
  output logic signed [VALUE_W-1:0]      out_front_value,
  output logic signed [VALUE_W-1:0]      out_rear_value,
  output logic                           out_is_empty,
  output logic                           out_is_full
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW = $clog2(DEPTH + 1);
  localparam int LW = (DW > CAP_W) ? DW : CAP_W;

  logic [CAP_W-1:0]          cap_r;
  logic [KIND_W-1:0]         kind_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [IW-1:0]             head_r, head_nxt;
  logic [IW-1:0]             tail_r, tail_nxt;
  logic                      empty_r, empty_nxt;
  logic                      acc_r, acc_nxt;
  logic signed [VALUE_W-1:0] mem [DEPTH];
  logic signed [VALUE_W-1:0] rd_front_r, rd_rear_r;
  logic                      out_valid_r;
  logic                      out_accepted_r, out_is_empty_r, out_is_full_r;
  logic signed [VALUE_W-1:0] out_front_r, out_rear_r;

  logic [LW-1:0] cap_ext, eff_cap;
  logic [LW-1:0] head_p1, tail_p1;
  logic [IW-1:0] head_inc, head_dec, tail_inc, tail_dec, cap_last;
  logic          full_now;
  logic          we;
  logic [IW-1:0] waddr;

  // effective capacity: zero acts as one, clamp at DEPTH
  always_comb begin
    cap_ext = LW'(cap_r);
    if (cap_ext == '0) begin
      eff_cap = LW'(1);
    end else if (cap_ext > LW'(DEPTH)) begin
      eff_cap = LW'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign cap_last = IW'(eff_cap - LW'(1));
  assign head_p1  = LW'(head_r) + LW'(1);
  assign tail_p1  = LW'(tail_r) + LW'(1);
  assign head_inc = (head_p1 >= eff_cap) ? '0 : IW'(head_p1);
  assign tail_inc = (tail_p1 >= eff_cap) ? '0 : IW'(tail_p1);
  assign head_dec = (head_r == '0) ? cap_last : head_r - IW'(1);
  assign tail_dec = (tail_r == '0) ? cap_last : tail_r - IW'(1);
  assign full_now = !empty_r && (tail_inc == head_r);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    empty_nxt = empty_r;
    acc_nxt   = 1'b0;
    we        = 1'b0;
    waddr     = '0;
    case (kind_r)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (!full_now) begin
          acc_nxt = 1'b1;
          we      = 1'b1;
          if (empty_r) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            empty_nxt = 1'b0;
            waddr     = '0;
          end else if (kind_r == KIND_PUSH_FRONT) begin
            head_nxt = head_dec;
            waddr    = head_dec;
          end else begin
            tail_nxt = tail_inc;
            waddr    = tail_inc;
          end
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (!empty_r) begin
          acc_nxt = 1'b1;
          if (head_r == tail_r) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            empty_nxt = 1'b1;
          end else if (kind_r == KIND_POP_FRONT) begin
            head_nxt = head_inc;
          end else begin
            tail_nxt = tail_dec;
          end
        end
      end
      default: begin
        acc_nxt = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cfg_we) begin
        cap_r   <= cfg_data;
        head_r  <= '0;
        tail_r  <= '0;
        empty_r <= 1'b1;
      end else if (cmd.exec) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        empty_r <= empty_nxt;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r  <= in_kind;
      value_r <= in_value;
    end
    if (cmd.exec) begin
      acc_r <= acc_nxt;
    end
    if (cmd.load_out) begin
      out_accepted_r <= acc_r;
      out_front_r    <= empty_r ? EMPTY_VALUE : rd_front_r;
      out_rear_r     <= empty_r ? EMPTY_VALUE : rd_rear_r;
      out_is_empty_r <= empty_r;
      out_is_full_r  <= full_now;
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (cmd.exec && we) begin
      mem[waddr] <= value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_front_r <= mem[head_r];
      rd_rear_r  <= mem[tail_r];
    end
  end

  assign sts.out_hold    = out_valid_r && out_stall;
  assign out_valid       = out_valid_r;
  assign out_accepted    = out_accepted_r;
  assign out_front_value = out_front_r;
  assign out_rear_value  = out_rear_r;
  assign out_is_empty    = out_is_empty_r;
  assign out_is_full     = out_is_full_r;

endmodule
`default_nettype wire

/* sv/circular_deque.sv */
`default_nettype none
// An accepted input transaction steps through execute, slot read and output load before
//   its result is valid on out_*. One transaction is taken at a time: the input stalls
//   through that sequence around the single-write, dual-read slot memory.
// A result waiting in the output register does not block the next input; that
//   next one waits in the load step, and the input stalls until the output frees.
// Reset (rst_n low, synchronous): deque empty, capacity 16, no result pending.
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue in a ring of signed 32-bit slots, wrapping at a
// programmable capacity. Each transaction pushes or pops at either end and
// returns acceptance, front and rear values, and the empty and full flags.
// A capacity write also empties the deque; slot contents are never cleared.
// ----------------------------------------------------------------------------
module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // capacity register write
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CAP_W-1:0]          cfg_capacity,
  // operation request
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [KIND_W-1:0]         in_kind,
  input  wire logic signed [VALUE_W-1:0] in_value,
  // result
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_accepted,
  output logic signed [VALUE_W-1:0]      out_front_value,
  output logic signed [VALUE_W-1:0]      out_rear_value,
  output logic                           out_is_empty,
  output logic                           out_is_full
);

  cdq_cmd_t cmd;
  cdq_sts_t sts;

  // Sequencer: takes one transaction at a time, steps it through execute and
  // slot read, then waits for room in the output register.
  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: pointers wrap by compare against the effective capacity;
  // front and rear come from two registered reads of the slot memory.
  cdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_data        (cfg_capacity),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_accepted    (out_accepted),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full)
  );

endmodule
`default_nettype wire
